FILE: rtl/varint_length_deframer_defines.svh
// Assertion macros for the varint length deframer.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef VARINT_LENGTH_DEFRAMER_DEFINES_SVH
`define VARINT_LENGTH_DEFRAMER_DEFINES_SVH

// Check cond in the same cycle as trig.
`define VLD_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("deframer check failed");

// Check cond in the cycle after trig.
`define VLD_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("deframer check failed");

`endif

FILE: rtl/vld_pkg.sv
// Shared types and constants for the varint length deframer.
// No dependencies.
`default_nettype none
package vld_pkg;

    localparam int unsigned LEN_W      = 28;
    localparam int unsigned NEED_W     = 29;
    localparam int unsigned PCNT_W     = 3;
    localparam int unsigned CTRL_TOTAL = 3;

    localparam logic [1:0] KIND_PREFIX  = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_CONTROL = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PREFIX  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CONTROL = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]        byte_kind;
        logic              frame_last;
        logic [NEED_W-1:0] still_needed;
        logic [LEN_W-1:0]  payload_length;
        logic [PCNT_W-1:0] prefix_length;
        logic [1:0]        control_length;
        logic              prefix_error;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/vld_core.sv
// Frame parser state and per-byte classification logic.
// Depends on vld_pkg.
`default_nettype none
module vld_core
    import vld_pkg::*;
#(
    parameter int unsigned MAX_PREFIX_BYTES = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_compressed,
    output t_result         o_res
);

    localparam int unsigned CNT_W = $clog2(MAX_PREFIX_BYTES + 1);

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_acc, n_acc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LEN_W-1:0]   r_left, n_left;

    logic [LEN_W-1:0]   acc_base;
    logic [LEN_W-1:0]   acc_new;
    logic [CNT_W-1:0]   cnt_base;
    logic [CNT_W-1:0]   cnt_new;
    logic [LEN_W-1:0]   left_dec;

    function automatic logic [NEED_W-1:0] report_need(input logic comp,
                                                       input logic [LEN_W-1:0] left);
        return comp ? NEED_W'(1) : NEED_W'(left);
    endfunction

    always_comb begin
        acc_base = (r_phase == PH_IDLE) ? '0 : r_acc;
        cnt_base = (r_phase == PH_IDLE) ? '0 : r_cnt;
        acc_new  = {acc_base[LEN_W-8:0], i_byte[6:0]};
        cnt_new  = cnt_base + CNT_W'(1);
        left_dec = r_left - LEN_W'(1);
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_left  = r_left;
        o_res   = '0;
        o_res.still_needed = NEED_W'(1);
        case (r_phase)
            PH_IDLE, PH_PREFIX: begin
                n_acc                = acc_new;
                n_cnt                = cnt_new;
                o_res.byte_kind      = KIND_PREFIX;
                o_res.payload_length = acc_new;
                o_res.prefix_length  = PCNT_W'(cnt_new);
                if (i_byte[7]) begin
                    if (32'(cnt_new) >= 32'(MAX_PREFIX_BYTES)) begin
                        o_res.prefix_error = 1'b1;
                        n_phase            = PH_IDLE;
                    end else begin
                        n_phase = PH_PREFIX;
                    end
                end else if (acc_new == '0) begin
                    o_res.control_length = 2'(CTRL_TOTAL);
                    o_res.prefix_length  = '0;
                    if (32'(cnt_new) >= 32'(CTRL_TOTAL)) begin
                        o_res.frame_last   = 1'b1;
                        o_res.still_needed = '0;
                        n_left             = '0;
                        n_phase            = PH_IDLE;
                    end else begin
                        n_left             = LEN_W'(CTRL_TOTAL - 32'(cnt_new));
                        o_res.still_needed = report_need(i_compressed,
                                                         LEN_W'(CTRL_TOTAL - 32'(cnt_new)));
                        n_phase            = PH_CONTROL;
                    end
                end else begin
                    n_left             = acc_new;
                    o_res.still_needed = report_need(i_compressed, acc_new);
                    n_phase            = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD, PH_CONTROL: begin
                if (r_phase == PH_PAYLOAD) begin
                    o_res.byte_kind      = KIND_DATA;
                    o_res.payload_length = r_acc;
                    o_res.prefix_length  = PCNT_W'(r_cnt);
                end else begin
                    o_res.byte_kind      = KIND_CONTROL;
                    o_res.control_length = 2'(CTRL_TOTAL);
                end
                if (r_left <= LEN_W'(1)) begin
                    o_res.frame_last   = 1'b1;
                    o_res.still_needed = '0;
                    n_left             = '0;
                    n_phase            = PH_IDLE;
                end else begin
                    n_left             = left_dec;
                    o_res.still_needed = report_need(i_compressed, left_dec);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/varint_length_deframer.sv
// Varint length-prefixed deframer: one result per input byte.
// Each accepted byte is held in the input register; its result is then registered in the output register.
// Throughput: one byte per cycle while the output register is free or drained, set by the frame state update.
// Output register decouples the sides; input stalls only when both registers are full and the output is blocked.
// Reset (synchronous, active low) awaits a prefix, clears both stages, stream_compressed 0.
// Depends on vld_pkg, vld_core and varint_length_deframer_defines.svh.
`default_nettype none
`include "varint_length_deframer_defines.svh"
module varint_length_deframer
    import vld_pkg::*;
#(
    parameter int unsigned MAX_PREFIX_BYTES = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_stream_compressed,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_data_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_byte_kind,
    output logic                   o_frame_last,
    output logic [NEED_W-1:0]      o_still_needed,
    output logic [LEN_W-1:0]       o_payload_length,
    output logic [PCNT_W-1:0]      o_prefix_length,
    output logic [1:0]             o_control_length,
    output logic                   o_prefix_error
);

    logic       r_compressed;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    logic       advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    vld_core #(
        .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (r_in_byte),
        .i_compressed (r_compressed),
        .o_res        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed <= 1'b0;
        end else if (i_cfg_valid) begin
            r_compressed <= i_cfg_stream_compressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_kind      = r_out.byte_kind;
    assign o_frame_last     = r_out.frame_last;
    assign o_still_needed   = r_out.still_needed;
    assign o_payload_length = r_out.payload_length;
    assign o_prefix_length  = r_out.prefix_length;
    assign o_control_length = r_out.control_length;
    assign o_prefix_error   = r_out.prefix_error;

    `VLD_ASSERT_SAME(a_last_no_need, o_out_valid && o_frame_last, o_still_needed == '0)
    `VLD_ASSERT_SAME(a_err_restart, o_out_valid && o_prefix_error,
        !o_frame_last && (o_still_needed == NEED_W'(1)) && (o_byte_kind == KIND_PREFIX))
    `VLD_ASSERT_SAME(a_prefix_last_ctrl,
        o_out_valid && o_frame_last && (o_byte_kind == KIND_PREFIX),
        o_control_length == 2'(CTRL_TOTAL))
    `VLD_ASSERT_NEXT(a_stall_holds, r_in_valid && !advance, r_in_valid)

endmodule
`default_nettype wire
